FILE: rtl/bsa_pkg.sv
// Shared constants, request codes and sizes for the bitmap slot allocator.
package bsa_pkg;

	// Size of the slot map and the reach of the 10-bit index fields.
	localparam int MAX_BITS   = 1024;
	localparam int INDEX_REACH = 1024;
	localparam int WORD_W     = 64;
	localparam int BIT_AW     = $clog2(WORD_W);
	localparam int IDX_W      = 10;
	localparam int CNT_W      = 11;

	// Only words that an index below the effective count can reach are stored.
	localparam int EFF_MAX    = (MAX_BITS < INDEX_REACH) ? MAX_BITS : INDEX_REACH;
	localparam int WORDS      = (EFF_MAX + WORD_W - 1) / WORD_W;
	localparam int WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

	localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(1024);
	localparam logic [CNT_W-1:0] EFF_MAX_CNT  = CNT_W'(EFF_MAX);

	typedef enum logic [1:0] {
		MODE_TEST  = 2'd0,
		MODE_SET   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_ALLOC = 2'd3
	} mode_t;

endpackage

FILE: rtl/bsa_if.sv
// Handshake channels of the bitmap slot allocator: request, response and configuration.
interface bsa_req_if import bsa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       mode;
	logic [IDX_W-1:0] bit_index;

	modport source (output valid, output mode, output bit_index, input ready);
	modport sink   (input valid, input mode, input bit_index, output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             ok;
	logic             bit_value;
	logic [IDX_W-1:0] allocated_index;

	modport source (output valid, output ok, output bit_value, output allocated_index,
		input ready);
	modport sink   (input valid, input ok, input bit_value, input allocated_index,
		output ready);
endinterface

interface bsa_cfg_if import bsa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] active_bits;

	modport source (output valid, output active_bits, input ready);
	modport sink   (input valid, input active_bits, output ready);
endinterface

FILE: rtl/bitmap_slot_allocator_core.sv
// Bitmap slot allocator: one-bit-per-slot map held in a 64-bit-wide RAM, with test, set,
// clear and allocate-lowest-free requests; one response item per request item.
//
// The slot map lives in a RAM of 64-bit words with a registered read. A request item is
// taken when the block is idle; that cycle issues the read of the addressed word, or of
// word 0 for allocate. Test, set and clear finish in the scan state that follows, where
// the word is examined, modified and written back once the output register is free.
// Allocate starts at word 0 and reads one word per cycle until it finds a clear bit below
// the active count or runs past it, and then finishes once the output register is free.
// A finished response item sits in an output register, so the next request item can be
// taken while the response still waits to be taken; a second result then waits until
// that register frees up. No clearing pass is needed after reset: one valid flag per
// word, cleared by reset, makes an unwritten word read as all free. The active_bits
// register may only be written while no request is in flight; an index at or above
// min(active_bits, 1024) is rejected with ok low.
module bitmap_slot_allocator_core import bsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	bsa_req_if.sink  req,
	bsa_rsp_if.source rsp,
	bsa_cfg_if.sink  cfg
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t state_q;

	// Configuration register.
	logic [CNT_W-1:0] active_bits_q;
	logic [CNT_W-1:0] eff_count;

	// Request held for the memory stage.
	mode_t              mode_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [CNT_W-1:0]   cnt_s1;
	logic [WORD_AW-1:0] word_s1;

	// Per-word written flags; an unwritten word reads as all zero.
	logic [WORDS-1:0] written_q;

	// RAM ports.
	logic               ram_wr_en;
	logic [WORD_W-1:0]  ram_wr_data;
	logic               ram_rd_en;
	logic [WORD_AW-1:0] ram_rd_addr;
	logic [WORD_W-1:0]  ram_rd_data;

	// Output register.
	logic             rsp_valid_q;
	logic             ok_q;
	logic             bit_value_q;
	logic [IDX_W-1:0] alloc_idx_q;

	// Memory stage decode.
	logic [WORD_W-1:0] word_data;
	logic [CNT_W-1:0]  base;
	logic [CNT_W-1:0]  next_base;
	logic [CNT_W-1:0]  rem;
	logic [WORD_W-1:0] lim_mask;
	logic [WORD_W-1:0] free_bits;
	logic              found;
	logic [BIT_AW-1:0] free_pos;
	logic [WORD_W-1:0] bit_mask;
	logic [WORD_W-1:0] alloc_mask;
	logic              in_range;
	logic              next_ok;
	logic              out_free;
	logic              is_alloc;
	logic              step_word;
	logic              finish;
	logic              req_fire;

	// The count in force is bounded by the map size and the reach of the index fields.
	assign eff_count = (active_bits_q > EFF_MAX_CNT) ? EFF_MAX_CNT : active_bits_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bits_q <= ACTIVE_RESET;
		end else if (cfg.valid) begin
			active_bits_q <= cfg.active_bits;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	// The RAM data of a word is used only if the word has been written; otherwise it reads as zero.
	assign word_data = written_q[word_s1] ? ram_rd_data : '0;

	assign base      = CNT_W'(word_s1) << BIT_AW;
	assign next_base = (CNT_W'(word_s1) + CNT_W'(1)) << BIT_AW;
	assign rem       = cnt_s1 - base;

	// Bits of this word whose index lies below the active count.
	always_comb begin
		if (cnt_s1 <= base) begin
			lim_mask = '0;
		end else if (rem >= CNT_W'(WORD_W)) begin
			lim_mask = '1;
		end else begin
			lim_mask = (WORD_W'(1) << rem[BIT_AW-1:0]) - WORD_W'(1);
		end
	end

	assign free_bits = ~word_data & lim_mask;
	assign found     = |free_bits;

	// Lowest free position in the word.
	always_comb begin
		free_pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				free_pos = BIT_AW'(i);
			end
		end
	end

	assign bit_mask   = WORD_W'(1) << idx_s1[BIT_AW-1:0];
	assign alloc_mask = WORD_W'(1) << free_pos;
	assign in_range   = CNT_W'(idx_s1) < cnt_s1;
	assign next_ok    = next_base < cnt_s1;
	assign is_alloc   = (mode_s1 == MODE_ALLOC);
	assign out_free   = !rsp_valid_q || rsp.ready;

	// An allocate that found nothing here moves on to the next word if any of it is active.
	assign step_word = (state_q == ST_SCAN) && is_alloc && !found && next_ok;
	assign finish    = (state_q == ST_SCAN) && !step_word && out_free;

	// Read issue: the addressed word on accept, the following word while scanning.
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = word_s1 + WORD_AW'(1);
		if (req_fire) begin
			ram_rd_en = 1'b1;
			if (mode_t'(req.mode) == MODE_ALLOC) begin
				ram_rd_addr = '0;
			end else begin
				ram_rd_addr = WORD_AW'(req.bit_index[IDX_W-1:BIT_AW]);
			end
		end else if (step_word) begin
			ram_rd_en = 1'b1;
		end
	end

	// Write-back happens only in the finishing cycle; the next read of the same word is issued
	// only after the state has returned to idle, so no forwarding path is needed.
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_data = word_data;
		if (finish) begin
			case (mode_s1)
				MODE_ALLOC: begin
					ram_wr_en   = found;
					ram_wr_data = word_data | alloc_mask;
				end
				MODE_SET: begin
					ram_wr_en   = in_range;
					ram_wr_data = word_data | bit_mask;
				end
				MODE_CLEAR: begin
					ram_wr_en   = in_range;
					ram_wr_data = word_data & ~bit_mask;
				end
				default: begin
					ram_wr_en = 1'b0;
				end
			endcase
		end
	end

	bsa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (word_s1),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			written_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ram_wr_en) begin
				written_q[word_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_s1 <= mode_t'(req.mode);
			idx_s1  <= req.bit_index;
			cnt_s1  <= eff_count;
			if (mode_t'(req.mode) == MODE_ALLOC) begin
				word_s1 <= '0;
			end else begin
				word_s1 <= WORD_AW'(req.bit_index[IDX_W-1:BIT_AW]);
			end
		end else if (step_word) begin
			word_s1 <= word_s1 + WORD_AW'(1);
		end
	end

	// Output register: loaded by a finishing request, emptied when the sink takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (is_alloc) begin
				ok_q        <= found;
				bit_value_q <= 1'b0;
				alloc_idx_q <= found ? IDX_W'(base + CNT_W'(free_pos)) : '0;
			end else begin
				ok_q        <= in_range;
				bit_value_q <= in_range && (mode_s1 == MODE_TEST) && |(word_data & bit_mask);
				alloc_idx_q <= '0;
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.ok              = ok_q;
	assign rsp.bit_value       = bit_value_q;
	assign rsp.allocated_index = alloc_idx_q;

endmodule

FILE: rtl/bsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/bsa_checker.sv
// Port-level checks for the bitmap slot allocator and the bind that attaches them.
module bsa_checker import bsa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic             rsp_ok,
	input logic             rsp_bit_value,
	input logic [IDX_W-1:0] rsp_allocated_index
);

	// Items accepted but not yet delivered; at most one in work and one in the output register.
	logic [1:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({req_valid && req_ready, rsp_valid && rsp_ready})
				2'b10:   pending_q <= (pending_q == 2'd3) ? pending_q : pending_q + 2'd1;
				2'b01:   pending_q <= (pending_q == 2'd0) ? pending_q : pending_q - 2'd1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
			$stable(rsp_bit_value) && $stable(rsp_allocated_index))
		else $error("response item changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response item without an accepted request item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2)
		else $error("more than two request items outstanding");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> !rsp_bit_value && rsp_allocated_index == '0)
		else $error("failed response carries a bit value or an index");

	a_test_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_bit_value |-> rsp_ok && rsp_allocated_index == '0)
		else $error("test response carries an allocated index");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_ok              (rsp.ok),
	.rsp_bit_value       (rsp.bit_value),
	.rsp_allocated_index (rsp.allocated_index)
);

FILE: sim/testbench.sv
// Self-checking testbench for bitmap_slot_allocator_core: directed table, then random phases.
module testbench;
	import bsa_pkg::*;

	// One response item as the block returns it, compared field by field.
	typedef struct packed {
		logic             ok;
		logic             bit_value;
		logic [IDX_W-1:0] allocated_index;
	} slot_rsp_t;

	// A row of the directed table is either a request item or a write of active_bits.
	typedef enum logic {
		ROW_REQ = 1'b0,
		ROW_CFG = 1'b1
	} row_kind_t;

	// Rows marked known carry a response typed in by hand; the others use the predictor.
	typedef struct {
		row_kind_t        kind;
		logic             known;
		mode_t            op;
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] count;
		slot_rsp_t        rsp;
	} stim_row_t;

	localparam int unsigned WATCHDOG_LIMIT   = 2000;
	localparam int unsigned LONG_HOLD_CYCLES = 200;
	localparam int unsigned LONG_HOLD_AFTER  = 300;
	localparam int unsigned DRAIN_CYCLES     = 4;
	localparam int unsigned TAIL_CYCLES      = 20;

	logic clk = 1'b0;
	logic arst_n;

	bsa_req_if req_ch ();
	bsa_rsp_if rsp_ch ();
	bsa_cfg_if cfg_ch ();

	bitmap_slot_allocator_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// Free-running clock, period 12.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the slot map and of the active_bits register, kept by the predictor.
	logic [WORD_W-1:0] slot_map [WORDS];
	logic [CNT_W-1:0]  active_count;

	// Responses still owed by the block, oldest first.
	slot_rsp_t   pending_rsp_q[$];
	stim_row_t   stim_table[$];

	int unsigned error_count = 0;
	int unsigned rsp_total = 0;
	int unsigned mode_tally [4];
	int unsigned alloc_granted;
	int unsigned alloc_refused;
	int unsigned access_rejected;
	int unsigned cfg_writes;
	int unsigned burst_left;
	int unsigned idle_cycles = 0;

	slot_rsp_t   got_rsp;
	slot_rsp_t   want_rsp;

	// Applies one request item to the shadow map and returns the response it should give.
	// The usable range is active_bits capped at the size of the map; allocate takes the
	// lowest clear bit inside it, and every other request fails outside it.
	function automatic slot_rsp_t predict_slot_op(input mode_t op, input logic [IDX_W-1:0] idx);
		slot_rsp_t   r;
		int unsigned limit;
		int unsigned c;
		r = '0;
		limit = (active_count > EFF_MAX) ? EFF_MAX : active_count;
		if (op == MODE_ALLOC) begin
			for (c = 0; c < limit && !r.ok; c++) begin
				if (!slot_map[(c / WORD_W) % WORDS][c % WORD_W]) begin
					slot_map[(c / WORD_W) % WORDS][c % WORD_W] = 1'b1;
					r.ok = 1'b1;
					r.allocated_index = IDX_W'(c);
				end
			end
		end else if (idx < limit) begin
			r.ok = 1'b1;
			case (op)
				MODE_TEST: begin
					r.bit_value = slot_map[(idx / WORD_W) % WORDS][idx % WORD_W];
				end
				MODE_SET: begin
					slot_map[(idx / WORD_W) % WORDS][idx % WORD_W] = 1'b1;
				end
				default: begin
					slot_map[(idx / WORD_W) % WORDS][idx % WORD_W] = 1'b0;
				end
			endcase
		end
		return r;
	endfunction

	task automatic add_req(input mode_t op, input logic [IDX_W-1:0] idx);
		stim_row_t row;
		row.kind = ROW_REQ;
		row.known = 1'b0;
		row.op = op;
		row.index = idx;
		row.count = '0;
		row.rsp = '0;
		stim_table.push_back(row);
	endtask

	task automatic add_known(input mode_t op, input logic [IDX_W-1:0] idx, input logic ok,
		input logic bit_value, input logic [IDX_W-1:0] alloc_idx);
		stim_row_t row;
		row.kind = ROW_REQ;
		row.known = 1'b1;
		row.op = op;
		row.index = idx;
		row.count = '0;
		row.rsp = '{ok: ok, bit_value: bit_value, allocated_index: alloc_idx};
		stim_table.push_back(row);
	endtask

	task automatic add_cfg(input logic [CNT_W-1:0] count);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.known = 1'b0;
		row.op = MODE_TEST;
		row.index = '0;
		row.count = count;
		row.rsp = '0;
		stim_table.push_back(row);
	endtask

	// Offers one request item and waits for it to be taken. The expectation is queued at
	// the edge where the item is accepted. The sender works in bursts: when one ends, a
	// random gap follows, and some bursts are long and run with no gap at all.
	task automatic send_request(input mode_t op, input logic [IDX_W-1:0] idx,
		input logic known, input slot_rsp_t known_rsp);
		slot_rsp_t   predicted;
		int unsigned gap;
		req_ch.valid <= 1'b1;
		req_ch.mode <= op;
		req_ch.bit_index <= idx;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = predict_slot_op(op, idx);
		pending_rsp_q.push_back(known ? known_rsp : predicted);
		mode_tally[op]++;
		if (op == MODE_ALLOC) begin
			if (predicted.ok) alloc_granted++;
			else alloc_refused++;
		end else if (!predicted.ok) begin
			access_rejected++;
		end
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stops offering items until every owed response has come back, then lets the block
	// settle so that nothing is left in flight.
	task automatic wait_for_responses();
		req_ch.valid <= 1'b0;
		while (pending_rsp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// active_bits may only change while no request is in flight, so drain first.
	task automatic write_active_bits(input logic [CNT_W-1:0] count);
		wait_for_responses();
		cfg_ch.valid <= 1'b1;
		cfg_ch.active_bits <= count;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		active_count = count;
		cfg_writes++;
	endtask

	// One random phase under a fixed active_bits setting. A fill phase is mostly allocate,
	// which walks the free point up through the map so that long scans and high indices
	// appear; other phases mix all four requests. Most indices land inside the usable
	// range, the rest anywhere in the 10-bit field.
	task automatic run_random_phase(input logic [CNT_W-1:0] count, input int unsigned items,
		input bit fill);
		int unsigned      n;
		int unsigned      pick;
		int unsigned      eff;
		mode_t            op;
		logic [IDX_W-1:0] idx;
		write_active_bits(count);
		eff = (count > EFF_MAX) ? EFF_MAX : count;
		for (n = 0; n < items; n++) begin
			pick = $urandom_range(0, 99);
			if (fill) begin
				op = (pick < 92) ? MODE_ALLOC : (pick < 96) ? MODE_TEST :
					(pick < 98) ? MODE_SET : MODE_CLEAR;
			end else begin
				op = mode_t'($urandom_range(0, 3));
			end
			if (eff > 0 && $urandom_range(0, 9) < 7) idx = IDX_W'($urandom_range(0, eff - 1));
			else idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
			send_request(op, idx, 1'b0, '0);
			// Halfway through the fill, the sender waits until the block has answered
			// everything before it carries on.
			if (fill && n == items / 2) wait_for_responses();
		end
	endtask

	// Response checker: every accepted response item is matched against the oldest
	// expectation. Values are those before this edge's updates, so no race with the block.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rsp_total++;
			got_rsp.ok = rsp_ch.ok;
			got_rsp.bit_value = rsp_ch.bit_value;
			got_rsp.allocated_index = rsp_ch.allocated_index;
			if (pending_rsp_q.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("tb: response with nothing expected: ok=%0b bit=%0b idx=%0d",
						got_rsp.ok, got_rsp.bit_value, got_rsp.allocated_index);
			end else begin
				want_rsp = pending_rsp_q.pop_front();
				if (got_rsp.ok !== want_rsp.ok || got_rsp.bit_value !== want_rsp.bit_value ||
					got_rsp.allocated_index !== want_rsp.allocated_index) begin
					error_count++;
					if (error_count <= 10) begin
						$display("tb: mismatch on response %0d: expected ok=%0b bit=%0b idx=%0d",
							rsp_total, want_rsp.ok, want_rsp.bit_value,
							want_rsp.allocated_index);
						$display("tb:   got ok=%0b bit=%0b idx=%0d",
							got_rsp.ok, got_rsp.bit_value, got_rsp.allocated_index);
					end
				end
			end
		end
	end

	// Watchdog: ends the run when no handshake of any kind has happened for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("tb: no progress for %0d cycles, %0d responses outstanding",
				WATCHDOG_LIMIT, pending_rsp_q.size());
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: ready follows a random 16-bit stall pattern that is redrawn again and again,
	// sometimes all ones so that there are stretches with no stall. Once, after a few
	// hundred responses, ready is held low for a long stretch while the sender keeps
	// going, so the output register and the request path both back up.
	initial begin : rsp_ready_gen
		int unsigned step;
		logic [15:0] stall_pattern;
		bit          long_hold_done;
		rsp_ch.ready <= 1'b0;
		step = 0;
		stall_pattern = '1;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && rsp_total >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			if (step % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pattern = '1;
					1: stall_pattern = 16'($urandom);
					2: stall_pattern = 16'($urandom) | 16'($urandom);
					default: stall_pattern = 16'($urandom) & 16'($urandom);
				endcase
			end
			rsp_ch.ready <= stall_pattern[step % 16];
			step++;
		end
	end

	initial begin : stimulus
		int unsigned r;
		int unsigned w;
		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_TEST;
		req_ch.bit_index <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.active_bits <= ACTIVE_RESET;
		arst_n <= 1'b0;
		alloc_granted = 0;
		alloc_refused = 0;
		access_rejected = 0;
		cfg_writes = 0;
		burst_left = 1;
		for (w = 0; w < 4; w++) mode_tally[w] = 0;
		for (w = 0; w < WORDS; w++) slot_map[w] = '0;
		active_count = ACTIVE_RESET;

		// Directed table. Right after reset the map is empty and all 1024 bits are usable.
		add_known(MODE_TEST, 10'd0, 1'b1, 1'b0, 10'd0);
		add_known(MODE_TEST, 10'd1023, 1'b1, 1'b0, 10'd0);
		add_known(MODE_SET, 10'd1023, 1'b1, 1'b0, 10'd0);
		add_req(MODE_TEST, 10'd1023);
		add_known(MODE_ALLOC, 10'd777, 1'b1, 1'b0, 10'd0);
		add_known(MODE_ALLOC, 10'd0, 1'b1, 1'b0, 10'd1);
		add_known(MODE_CLEAR, 10'd0, 1'b1, 1'b0, 10'd0);
		add_req(MODE_ALLOC, 10'd1023);
		add_req(MODE_SET, 10'b1010101010);
		add_req(MODE_TEST, 10'b0101010101);
		add_req(MODE_CLEAR, 10'd1023);
		// With a zero count, every kind of request fails.
		add_cfg(11'd0);
		add_known(MODE_TEST, 10'd1, 1'b0, 1'b0, 10'd0);
		add_known(MODE_SET, 10'd5, 1'b0, 1'b0, 10'd0);
		add_known(MODE_CLEAR, 10'd0, 1'b0, 1'b0, 10'd0);
		add_known(MODE_ALLOC, 10'd0, 1'b0, 1'b0, 10'd0);
		// One usable bit, already set: allocate finds the map full, and bit 1 is hidden
		// even though it is set.
		add_cfg(11'd1);
		add_known(MODE_ALLOC, 10'd0, 1'b0, 1'b0, 10'd0);
		add_known(MODE_TEST, 10'd0, 1'b1, 1'b1, 10'd0);
		add_known(MODE_TEST, 10'd1, 1'b0, 1'b0, 10'd0);
		// A count past the map size is capped at 1024; bit 1 is visible again.
		add_cfg(11'd2047);
		add_req(MODE_TEST, 10'd1);
		add_known(MODE_SET, 10'd1023, 1'b1, 1'b0, 10'd0);
		add_req(MODE_ALLOC, 10'd0);
		// A count one past a word boundary.
		add_cfg(11'd65);
		add_known(MODE_TEST, 10'd65, 1'b0, 1'b0, 10'd0);
		add_req(MODE_SET, 10'd64);
		add_req(MODE_ALLOC, 10'd0);
		add_known(MODE_TEST, 10'd1023, 1'b0, 1'b0, 10'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < stim_table.size(); r++) begin
			if (stim_table[r].kind == ROW_CFG)
				write_active_bits(stim_table[r].count);
			else
				send_request(stim_table[r].op, stim_table[r].index, stim_table[r].known,
					stim_table[r].rsp);
		end

		// Random part: a long fill under the full count, then a spread of settings that
		// includes both extremes of the register, word boundaries and random counts.
		run_random_phase(11'd1024, 640, 1'b1);
		run_random_phase(11'd2047, 70, 1'b0);
		run_random_phase(11'd0, 50, 1'b0);
		run_random_phase(11'd1, 60, 1'b0);
		run_random_phase(11'd64, 70, 1'b0);
		run_random_phase(11'd65, 70, 1'b0);
		run_random_phase(CNT_W'($urandom_range(1, 1100)), 70, 1'b0);
		run_random_phase(11'd1024, 80, 1'b0);
		run_random_phase(CNT_W'($urandom_range(1, 1100)), 70, 1'b0);
		run_random_phase(11'd130, 70, 1'b0);

		wait_for_responses();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: %0d requests (test %0d, set %0d, clear %0d, allocate %0d)",
			mode_tally[MODE_TEST] + mode_tally[MODE_SET] + mode_tally[MODE_CLEAR] +
			mode_tally[MODE_ALLOC], mode_tally[MODE_TEST], mode_tally[MODE_SET],
			mode_tally[MODE_CLEAR], mode_tally[MODE_ALLOC]);
		$display("tb: %0d active_bits settings, %0d slots granted, %0d refused, %0d rejected",
			cfg_writes, alloc_granted, alloc_refused, access_rejected);
		$display("tb: %0d errors", error_count);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
